### hdl/rsa_pkg.sv
package rsa_pkg;
    localparam int OPERAND_BITS = 32;
    localparam int CFG_WIDTH = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_SIGN_EXP = 2'd1;
    localparam logic [1:0] REG_VERIFY_EXP = 2'd2;

    typedef struct packed {
        logic start;
        logic active;
    } t_ctl;
endpackage

### hdl/rsa_cell.sv
module rsa_cell (
    input  logic         i_clk,
    input  rsa_pkg::t_ctl i_ctl,
    input  logic         i_rem_in,
    input  logic         i_qbit,
    input  logic         i_mbit,
    input  logic         i_borrow_in,
    output logic         o_rem,
    output logic         o_borrow
);
    logic r_rem;
    logic n_rem;
    logic d;

    // one bit of the partial remainder; a row of these forms a shift-subtract reducer
    assign d = i_rem_in ^ i_mbit ^ i_borrow_in;
    assign o_borrow = (~i_rem_in & (i_mbit | i_borrow_in)) | (i_mbit & i_borrow_in);
    assign o_rem = r_rem;

    always_comb begin
        n_rem = r_rem;
        if (i_ctl.start) begin
            n_rem = 1'b0;
        end else if (i_ctl.active) begin
            n_rem = i_qbit ? d : i_rem_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end
endmodule

### hdl/rsa_modexp_sign_verify.sv
// Modular exponentiation, one item at a time. For exponent e with highest set
// bit at position k and p set bits, an item takes k+1+p modular products (none
// for e == 0). Each modular product is a shift-add multiply followed by a row of
// OPERAND_BITS+1 remainder cells that reduce one product bit per cycle (skipped
// for a zero modulus, which keeps the low product bits). busy drops in the
// o_valid cycle, so the next item can be accepted then; the result stands for
// one cycle only and must be taken then, since the receiver cannot stall it.
module rsa_modexp_sign_verify #(
    parameter int OPERAND_BITS = rsa_pkg::OPERAND_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_kind,
    input  logic [31:0]                     i_message,
    input  logic [31:0]                     i_signature,
    input  logic                            i_cfg_we,
    input  logic [rsa_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [rsa_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    output logic                            o_valid,
    output logic [31:0]                     o_result_value,
    output logic                            o_signature_ok
);
    localparam int W = OPERAND_BITS;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(PW + 1);
    localparam int EW = $clog2(W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL = 3'd1;
    localparam logic [2:0] S_RED = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [W-1:0] r_mod, r_sexp, r_vexp;
    logic [2:0] r_state;
    logic [W-1:0] r_base, r_acc, r_exp, r_msg;
    logic r_kind, r_sq;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] r_cnt;
    logic [EW-1:0] r_mcnt;
    logic [W-1:0] r_mul_a, r_mul_b;
    logic r_valid;
    logic [31:0] r_res;
    logic r_ok;

    rsa_pkg::t_ctl ctl;
    logic [W:0] rem;
    logic [W+1:0] brw;
    logic geq;

    // remainder row: rem is shifted left with next product bit entering cell 0
    assign brw[0] = 1'b0;
    genvar g;
    generate
        for (g = 0; g <= W; g++) begin : g_cell
            logic rin;
            logic mb;
            if (g == 0) begin : g_lo
                assign rin = r_prod[PW-1];
            end else begin : g_hi
                assign rin = rem[g-1];
            end
            if (g < W) begin : g_m
                assign mb = r_mod[g];
            end else begin : g_mt
                assign mb = 1'b0;
            end
            rsa_cell u_cell (
                .i_clk(i_clk), .i_ctl(ctl),
                .i_rem_in(rin), .i_qbit(geq), .i_mbit(mb),
                .i_borrow_in(brw[g]), .o_rem(rem[g]),
                .o_borrow(brw[g+1])
            );
        end
    endgenerate
    assign geq = ~brw[W+1];

    // shift-add multiply of r_mul_a by the bits of r_mul_b
    logic [PW-1:0] addend;
    assign addend = r_mul_b[0] ? {{W{1'b0}}, r_mul_a} << r_mcnt : '0;

    assign ctl.start = (r_state == S_MUL) && (r_mcnt == EW'(W)) && (r_mod != '0);
    assign ctl.active = (r_state == S_RED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mod <= W'(1);
            r_sexp <= W'(1);
            r_vexp <= W'(1);
        end else begin
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsa_pkg::REG_MODULUS: r_mod <= i_cfg_data[W-1:0];
                    rsa_pkg::REG_SIGN_EXP: r_sexp <= i_cfg_data[W-1:0];
                    rsa_pkg::REG_VERIFY_EXP: r_vexp <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind <= i_kind;
                        r_msg <= i_message[W-1:0];
                        r_base <= i_kind ? i_signature[W-1:0] : i_message[W-1:0];
                        r_exp <= i_kind ? r_vexp : r_sexp;
                        r_acc <= W'(1);
                        r_state <= ((i_kind ? r_vexp : r_sexp) != '0) ? S_MUL : S_DONE;
                        if ((i_kind ? r_vexp : r_sexp) != '0) begin
                            r_sq <= ~(i_kind ? r_vexp[0] : r_sexp[0]);
                            r_mul_a <= i_kind ? i_signature[W-1:0] : i_message[W-1:0];
                            r_mul_b <= (i_kind ? r_vexp[0] : r_sexp[0]) ?
                                W'(1) : (i_kind ? i_signature[W-1:0] : i_message[W-1:0]);
                            r_prod <= '0;
                            r_mcnt <= '0;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mcnt == EW'(W)) begin
                        r_cnt <= (r_mod == '0) ? CW'(PW) : '0;
                        if (r_mod == '0) begin
                            r_prod <= {{W{1'b0}}, r_prod[W-1:0]};
                        end
                        r_state <= S_RED;
                    end else begin
                        r_prod <= r_prod + addend;
                        r_mul_b <= r_mul_b >> 1;
                        r_mcnt <= r_mcnt + EW'(1);
                    end
                end
                S_RED: begin
                    if (r_cnt != CW'(PW)) begin
                        r_prod <= r_prod << 1;
                        r_cnt <= r_cnt + CW'(1);
                    end else begin
                        logic [W-1:0] red;
                        red = (r_mod == '0) ? r_prod[W-1:0] : rem[W-1:0];
                        r_mcnt <= '0;
                        r_prod <= '0;
                        if (!r_sq) begin
                            // accumulator multiply done, now square base
                            r_acc <= red;
                            r_sq <= 1'b1;
                            r_mul_a <= r_base;
                            r_mul_b <= r_base;
                            r_state <= S_MUL;
                        end else begin
                            r_base <= red;
                            r_exp <= r_exp >> 1;
                            if (r_exp[W-1:1] == '0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_sq <= ~r_exp[1];
                                r_mul_a <= red;
                                r_mul_b <= r_exp[1] ? r_acc : red;
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_DONE: begin
                    r_res <= 32'(r_acc);
                    r_ok <= r_kind && (r_acc == r_msg);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_result_value = r_res;
    assign o_signature_ok = r_ok;

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("missing result");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE)) else $error("result while busy");
    a_sign_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_kind) |-> !o_signature_ok) else $error("ok on sign");
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic KIND_SIGN = 1'b0;
    localparam logic KIND_VERIFY = 1'b1;

    typedef struct {
        logic [31:0] value;
        logic        ok;
    } t_sig_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic                             i_kind = 1'b0;
    logic [31:0]                      i_message = '0;
    logic [31:0]                      i_signature = '0;
    logic                             i_cfg_we = 1'b0;
    logic [rsa_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [rsa_pkg::CFG_WIDTH-1:0]    i_cfg_data = '0;
    logic                             o_valid;
    logic [31:0]                      o_result_value;
    logic                             o_signature_ok;

    logic [31:0] key_modulus = 32'd1;
    logic [31:0] key_sign_exp = 32'd1;
    logic [31:0] key_verify_exp = 32'd1;

    t_sig_result pending_results[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    longint      cycle_count = 0;

    rsa_modexp_sign_verify dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] mod_power(logic [31:0] base_in, logic [31:0] expo,
                                              logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] b;
        acc = 64'd1;
        b = {32'd0, base_in};
        for (int i = 0; i < 32; i++) begin
            if ((expo >> i) == 0) break;
            if (expo[i]) acc = (m == 0) ? ((acc * b) & 64'hFFFF_FFFF) : (acc * b) % m;
            b = (m == 0) ? ((b * b) & 64'hFFFF_FFFF) : (b * b) % m;
        end
        return acc[31:0];
    endfunction

    function automatic t_sig_result predict_sig(logic kind, logic [31:0] msg,
                                                logic [31:0] sig);
        t_sig_result r;
        if (kind == KIND_SIGN) begin
            r.value = mod_power(msg, key_sign_exp, key_modulus);
            r.ok = 1'b0;
        end else begin
            r.value = mod_power(sig, key_verify_exp, key_modulus);
            r.ok = (r.value == msg);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%h ok=%b", $time,
                         o_result_value, o_signature_ok);
                errors++;
            end else begin
                t_sig_result e;
                e = pending_results.pop_front();
                if (o_result_value !== e.value) begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             e.value, o_result_value);
                    errors++;
                end
                if (o_signature_ok !== e.ok) begin
                    $display("%0t: signature_ok expected %b actual %b", $time,
                             e.ok, o_signature_ok);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic kind, logic [31:0] msg, logic [31:0] sig);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        start <= 1'b1;
        i_kind <= kind;
        i_message <= msg;
        i_signature <= sig;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
        end
        @(posedge i_clk);
        pending_results.push_back(predict_sig(kind, msg, sig));
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rsa_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rsa_pkg::REG_MODULUS:    key_modulus = data;
            rsa_pkg::REG_SIGN_EXP:   key_sign_exp = data;
            rsa_pkg::REG_VERIFY_EXP: key_verify_exp = data;
            default: ;
        endcase
    endtask

    task automatic set_key(logic [31:0] n, logic [31:0] e, logic [31:0] d);
        drain();
        write_reg(rsa_pkg::REG_MODULUS, n);
        write_reg(rsa_pkg::REG_SIGN_EXP, e);
        write_reg(rsa_pkg::REG_VERIFY_EXP, d);
    endtask

    task automatic test_reset_key();
        send_item(KIND_SIGN, 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_VERIFY, 32'h0, 32'h1234_5678);
    endtask

    task automatic test_textbook_key();
        set_key(32'd3233, 32'd17, 32'd2753);
        send_item(KIND_SIGN, 32'd65, 32'd0);
        send_item(KIND_VERIFY, 32'd65, 32'd2790);
        send_item(KIND_VERIFY, 32'd65, 32'd2791);
        send_item(KIND_SIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_VERIFY, 32'd0, 32'd0);
    endtask

    task automatic test_edge_keys();
        set_key(32'd1, 32'd0, 32'd0);
        send_item(KIND_SIGN, 32'd5, 32'd0);
        send_item(KIND_VERIFY, 32'd1, 32'hFFFF_FFFF);
        set_key(32'd0, 32'hFFFF_FFFF, 32'd3);
        send_item(KIND_SIGN, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_SIGN, 32'd3, 32'd0);
        send_item(KIND_VERIFY, 32'd27, 32'd3);
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(KIND_SIGN, 32'hFFFF_FFFE, 32'd0);
        send_item(KIND_VERIFY, 32'd0, 32'hFFFF_FFFF);
        send_item(KIND_VERIFY, 32'd1, 32'hFFFF_FFFE);
        set_key(32'd7, 32'd1, 32'd2);
        send_item(KIND_SIGN, 32'hFFFF_FFFF, 32'd0);
        send_item(KIND_VERIFY, 32'd2, 32'd10);
    endtask

    task automatic random_key();
        logic [31:0] n, e, d;
        case ($urandom_range(3))
            0: n = 32'd0;
            1: n = $urandom_range(65535, 1);
            default: n = $urandom;
        endcase
        e = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom;
        d = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom;
        set_key(n, e, d);
    endtask

    task automatic test_random_phase(int idle_pct, int count);
        logic [31:0] msg, sig;
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 15 == 0) random_key();
            msg = $urandom;
            sig = $urandom;
            if ($urandom_range(1)) begin
                send_item(KIND_SIGN, msg, sig);
            end else begin
                if ($urandom_range(1)) msg = mod_power(sig, key_verify_exp, key_modulus);
                send_item(KIND_VERIFY, msg, sig);
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_key();
        test_textbook_key();
        test_edge_keys();
        test_random_phase(18, 40);
        test_random_phase(69, 40);
        test_random_phase(0, 40);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
